/* sv/pcc_pkg.sv */
// Package for the pressure curve checker: constants, types, register indexes, status codes.
package pcc_pkg;

  // Default widths of the point pressures and the point counter
  localparam int PRESSURE_WIDTH_DEFAULT = 16;
  localparam int COUNT_WIDTH_DEFAULT    = 8;

  // Configuration register widths, fixed by the register map
  localparam int LIMIT_WIDTH    = 16;
  localparam int FEWEST_WIDTH   = 8;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 3;

  // A curve needs this many points before monotonicity means anything
  localparam int MIN_ORDER_POINTS = 2;

  // Register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PRELOAD_FLOOR     = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PRELOAD_CEILING   = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_AFTERLOAD_FLOOR   = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_AFTERLOAD_CEILING = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FEWEST_POINTS     = 3'd4;

  // Reset values of the registers
  localparam logic signed [LIMIT_WIDTH-1:0] PRELOAD_FLOOR_RESET     = 16'sd0;
  localparam logic signed [LIMIT_WIDTH-1:0] PRELOAD_CEILING_RESET   = 16'sd1280;
  localparam logic signed [LIMIT_WIDTH-1:0] AFTERLOAD_FLOOR_RESET   = 16'sd0;
  localparam logic signed [LIMIT_WIDTH-1:0] AFTERLOAD_CEILING_RESET = 16'sd9600;
  localparam logic [FEWEST_WIDTH-1:0]       FEWEST_POINTS_RESET     = 8'd2;

  // Curve status, in order of the codes
  typedef enum logic [1:0] {
    STATUS_SUCCESS = 2'd0,
    STATUS_TOO_FEW = 2'd1,
    STATUS_RANGE   = 2'd2,
    STATUS_ORDER   = 2'd3
  } status_t;

  // Live configuration handed to the checking logic
  typedef struct packed {
    logic signed [LIMIT_WIDTH-1:0] preload_floor;
    logic signed [LIMIT_WIDTH-1:0] preload_ceiling;
    logic signed [LIMIT_WIDTH-1:0] afterload_floor;
    logic signed [LIMIT_WIDTH-1:0] afterload_ceiling;
    logic [FEWEST_WIDTH-1:0]       fewest_points;
  } cfg_t;

endpackage

/* sv/pcc_ifs.sv */
// Stream interfaces for curve points and curve results.
interface pcc_point_if #(
  parameter int PressureWidth = 16
);
  logic                            valid;
  logic                            ready;
  logic signed [PressureWidth-1:0] preload;
  logic signed [PressureWidth-1:0] afterload;
  logic                            last_point;

  modport source (output valid, output preload, output afterload, output last_point,
                  input ready);
  modport sink   (input valid, input preload, input afterload, input last_point,
                  output ready);
endinterface

interface pcc_result_if #(
  parameter int CountWidth = 8
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [CountWidth-1:0] points_seen;

  modport source (output valid, output status, output points_seen, input ready);
  modport sink   (input valid, input status, input points_seen, output ready);
endinterface

/* sv/pcc_cfg_regs.sv */
// Configuration register bank of the pressure curve checker.
module pcc_cfg_regs
  import pcc_pkg::CFG_INDEX_WIDTH, pcc_pkg::CFG_DATA_WIDTH, pcc_pkg::cfg_t;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  output cfg_t                       cfg
);
  import pcc_pkg::*;

  // Register writes; an unknown index is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.preload_floor     <= PRELOAD_FLOOR_RESET;
      cfg.preload_ceiling   <= PRELOAD_CEILING_RESET;
      cfg.afterload_floor   <= AFTERLOAD_FLOOR_RESET;
      cfg.afterload_ceiling <= AFTERLOAD_CEILING_RESET;
      cfg.fewest_points     <= FEWEST_POINTS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PRELOAD_FLOOR:     cfg.preload_floor     <= cfg_data[LIMIT_WIDTH-1:0];
        REG_PRELOAD_CEILING:   cfg.preload_ceiling   <= cfg_data[LIMIT_WIDTH-1:0];
        REG_AFTERLOAD_FLOOR:   cfg.afterload_floor   <= cfg_data[LIMIT_WIDTH-1:0];
        REG_AFTERLOAD_CEILING: cfg.afterload_ceiling <= cfg_data[LIMIT_WIDTH-1:0];
        REG_FEWEST_POINTS:     cfg.fewest_points     <= cfg_data[FEWEST_WIDTH-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/pcc_curve_track.sv */
// Per-curve state and point checks: range, monotonicity, count and final status.
module pcc_curve_track
  import pcc_pkg::cfg_t, pcc_pkg::status_t;
#(
  parameter int PressureWidth = 16,
  parameter int CountWidth    = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic signed [PressureWidth-1:0] preload,
  input  logic signed [PressureWidth-1:0] afterload,
  input  logic                            last_point,
  input  cfg_t                            cfg,
  output status_t                         status,
  output logic [CountWidth-1:0]           points_seen
);
  import pcc_pkg::*;

  localparam int CmpPressure = (PressureWidth > LIMIT_WIDTH) ? PressureWidth : LIMIT_WIDTH;
  localparam int CmpCount    = (CountWidth > FEWEST_WIDTH) ? CountWidth : FEWEST_WIDTH;
  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  logic signed [PressureWidth-1:0] previous_preload;
  logic signed [PressureWidth-1:0] previous_afterload;
  logic [CountWidth-1:0]           point_count;
  logic                            range_failed;
  logic                            order_failed;

  logic signed [CmpPressure-1:0] pre_x;
  logic signed [CmpPressure-1:0] aft_x;
  logic                          range_bad;
  logic                          order_bad;
  logic [CountWidth-1:0]         point_count_next;
  logic                          range_failed_next;
  logic                          order_failed_next;

  // Limit and order checks on the current point
  always_comb begin
    pre_x     = CmpPressure'(preload);
    aft_x     = CmpPressure'(afterload);
    range_bad = (pre_x < CmpPressure'(cfg.preload_floor))
             || (pre_x > CmpPressure'(cfg.preload_ceiling))
             || (aft_x < CmpPressure'(cfg.afterload_floor))
             || (aft_x > CmpPressure'(cfg.afterload_ceiling));
    order_bad = (point_count != '0)
             && ((preload <= previous_preload) || (afterload < previous_afterload));
    point_count_next  = (point_count == CountMax) ? point_count : point_count + 1'b1;
    range_failed_next = range_failed | range_bad;
    order_failed_next = order_failed | order_bad;
  end

  // Final status, fixed priority
  always_comb begin
    if (CmpCount'(point_count_next) < CmpCount'(cfg.fewest_points)) begin
      status = STATUS_TOO_FEW;
    end else if (range_failed_next) begin
      status = STATUS_RANGE;
    end else if (order_failed_next
                 || (point_count_next < CountWidth'(MIN_ORDER_POINTS))) begin
      status = STATUS_ORDER;
    end else begin
      status = STATUS_SUCCESS;
    end
    points_seen = point_count_next;
  end

  // Curve state; the last point starts a fresh curve
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_preload   <= '0;
      previous_afterload <= '0;
      point_count        <= '0;
      range_failed       <= 1'b0;
      order_failed       <= 1'b0;
    end else if (step) begin
      if (last_point) begin
        previous_preload   <= '0;
        previous_afterload <= '0;
        point_count        <= '0;
        range_failed       <= 1'b0;
        order_failed       <= 1'b0;
      end else begin
        previous_preload   <= preload;
        previous_afterload <= afterload;
        point_count        <= point_count_next;
        range_failed       <= range_failed_next;
        order_failed       <= order_failed_next;
      end
    end
  end

endmodule

/* sv/pressure_curve_checker.sv */
// Pressure curve checker: top level with input register and result register.
//
// Points of a pressure curve arrive on the point channel, one request per point,
// with preload, afterload and a last_point mark. Each point is range checked and
// compared with the one before it. On the last point one request leaves on the
// result channel: status (success, too few points, out of range, non-monotonic)
// and the number of points seen, saturating at the counter maximum.
// A last point passes the input register, then the result register, before its
// result is offered on the result channel.
// Throughput: one point per cycle while no last point waits on a stalled
// receiver; the check between the two registers is combinational.
// Points that are not last produce no result and never wait on the receiver.
// When the receiver stalls, the result register holds; one more last point can
// sit in the input register behind it, and only then is the point channel held.
// Limits and the minimum point count are written on the plain configuration port
// and must only change while no curve is in progress.
// Reset (rst, synchronous) restores the register defaults, clears the curve
// state and empties both registers.
module pressure_curve_checker
  import pcc_pkg::CFG_INDEX_WIDTH, pcc_pkg::CFG_DATA_WIDTH,
         pcc_pkg::PRESSURE_WIDTH_DEFAULT, pcc_pkg::COUNT_WIDTH_DEFAULT;
#(
  parameter int PRESSURE_WIDTH = PRESSURE_WIDTH_DEFAULT,
  parameter int COUNT_WIDTH    = COUNT_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  pcc_point_if.sink                  point,
  pcc_result_if.source               result,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);
  import pcc_pkg::*;

  cfg_t cfg;

  logic                             s1_valid;
  logic signed [PRESSURE_WIDTH-1:0] s1_preload;
  logic signed [PRESSURE_WIDTH-1:0] s1_afterload;
  logic                             s1_last;
  logic                             s1_advance;
  logic                             point_take;

  status_t                          chk_status;
  logic [COUNT_WIDTH-1:0]           chk_points;

  logic                             out_valid;
  status_t                          out_status;
  logic [COUNT_WIDTH-1:0]           out_points;

  pcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pcc_curve_track #(
    .PressureWidth (PRESSURE_WIDTH),
    .CountWidth    (COUNT_WIDTH)
  ) u_track (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_advance),
    .preload     (s1_preload),
    .afterload   (s1_afterload),
    .last_point  (s1_last),
    .cfg         (cfg),
    .status      (chk_status),
    .points_seen (chk_points)
  );

  // Handshake: a last point moves on only when the result register can take it
  always_comb begin
    s1_advance  = s1_valid && (!s1_last || !out_valid || result.ready);
    point.ready = !s1_valid || s1_advance;
    point_take  = point.valid && point.ready;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (point_take) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
    if (point_take) begin
      s1_preload   <= point.preload;
      s1_afterload <= point.afterload;
      s1_last      <= point.last_point;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_advance && s1_last) begin
      out_status <= chk_status;
      out_points <= chk_points;
    end
  end

  assign result.valid       = out_valid;
  assign result.status      = out_status;
  assign result.points_seen = out_points;

endmodule
